// File: hdl/ptcd_pkg.sv
// ptcd_pkg: shared types and constants for the position telegram checker/decoder.
// No dependencies; used by every module in hdl/.
package ptcd_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEN     = 3'd1,
        ST_CHK     = 3'd2,
        ST_SENSOR  = 3'd3,
        ST_KIND    = 3'd4
    } status_t;

    // Outstanding request kind
    typedef enum logic [1:0] {
        KIND_DIR     = 2'd0,
        KIND_COLOR   = 2'd1,
        KIND_POS     = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    localparam int STORE_DEPTH = 18;   // data bytes kept per telegram
    localparam int QUEUE_DEPTH = 2;    // jobs between front and back

    localparam logic [4:0] COUNT_MAX = 5'd31;

    // bit positions inside the 7-bit data bytes
    localparam int FAULT_BIT  = 0;     // byte 0: sensor error
    localparam int NOLANE_BIT = 1;     // byte 0: lane not seen
    localparam int TAG_BIT    = 6;     // byte 1: tag in view

    typedef logic [6:0] data_t;

    // One finished telegram, handed from front to back
    typedef struct packed {
        kind_t                       kind;
        status_t                     status;  // ST_OK, ST_LEN, ST_CHK or ST_KIND
        data_t [STORE_DEPTH-1:0]     bytes;
    } job_t;

endpackage

// File: hdl/ptcd_front.sv
// ptcd_front: counts, XORs and stores telegram bytes; on the checksum word it
// classifies the telegram and builds a job. Depends on ptcd_pkg.
module ptcd_front #(
    parameter int DIR_REPLY_LEN   = 3,
    parameter int COLOR_REPLY_LEN = 3,
    parameter int POS_REPLY_LEN   = 21
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        cmd,
    input  logic [7:0]        rx_byte,
    input  logic              last,
    output logic              push,
    output ptcd_pkg::job_t    job
);

    localparam logic [4:0] DIR_COUNT   = 5'(DIR_REPLY_LEN - 1);
    localparam logic [4:0] COLOR_COUNT = 5'(COLOR_REPLY_LEN - 1);
    localparam logic [4:0] POS_COUNT   = 5'(POS_REPLY_LEN - 1);

    logic [4:0]            count_reg, count_next;
    logic [7:0]            xor_reg, xor_next;
    ptcd_pkg::data_t       store_reg [ptcd_pkg::STORE_DEPTH];
    ptcd_pkg::kind_t       kind;
    logic [4:0]            need_count;

    assign kind = ptcd_pkg::kind_t'(cmd);
    assign push = accept && last;

    always_comb begin
        case (kind)
            ptcd_pkg::KIND_DIR:   need_count = DIR_COUNT;
            ptcd_pkg::KIND_COLOR: need_count = COLOR_COUNT;
            ptcd_pkg::KIND_POS:   need_count = POS_COUNT;
            default:              need_count = POS_COUNT;
        endcase
    end

    always_comb begin
        job.kind = kind;
        for (int i = 0; i < ptcd_pkg::STORE_DEPTH; i++) begin
            job.bytes[i] = store_reg[i];
        end
        if (kind == ptcd_pkg::KIND_UNKNOWN) begin
            job.status = ptcd_pkg::ST_KIND;
        end else if (count_reg != need_count) begin
            job.status = ptcd_pkg::ST_LEN;
        end else if (xor_reg != rx_byte) begin
            job.status = ptcd_pkg::ST_CHK;
        end else begin
            job.status = ptcd_pkg::ST_OK;
        end
    end

    always_comb begin
        count_next = count_reg;
        xor_next   = xor_reg;
        if (accept) begin
            if (last) begin
                count_next = '0;
                xor_next   = '0;
            end else begin
                if (count_reg != ptcd_pkg::COUNT_MAX) begin
                    count_next = count_reg + 5'd1;
                end
                xor_next = xor_reg ^ rx_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            xor_reg   <= '0;
        end else begin
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    // byte store: entries past the depth are counted but not kept
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ptcd_pkg::STORE_DEPTH; i++) begin
            if (accept && !last && count_reg == 5'(i)) begin
                store_reg[i] <= rx_byte[6:0];
            end
        end
    end

endmodule

// File: hdl/ptcd_queue.sv
// ptcd_queue: small job FIFO between front and back.
// Depends on ptcd_pkg.
module ptcd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ptcd_pkg::job_t    push_job,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output ptcd_pkg::job_t    head_job
);

    localparam int PTR_W = (ptcd_pkg::QUEUE_DEPTH > 1) ? $clog2(ptcd_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ptcd_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(ptcd_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(ptcd_pkg::QUEUE_DEPTH - 1);

    ptcd_pkg::job_t      mem [ptcd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                do_push, do_pop;

    assign full      = (cnt_reg == DEPTH_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: hdl/ptcd_back.sv
// ptcd_back: applies a job to the stored decode values and holds the result word.
// Depends on ptcd_pkg.
module ptcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  ptcd_pkg::job_t      job,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output ptcd_pkg::status_t   status,
    output logic                lane_detected,
    output logic                tag_seen,
    output logic [27:0]         tag_number,
    output logic [23:0]         fault_code,
    output logic [1:0]          direction,
    output logic [2:0]          color,
    output logic signed [24:0]  x_position,
    output logic signed [14:0]  y_position,
    output logic [13:0]         heading
);

    logic                valid_reg, valid_next;
    ptcd_pkg::status_t   status_reg, status_next;
    logic                lane_reg, lane_next;
    logic                tag_reg, tag_next;
    logic [27:0]         tagnum_reg, tagnum_next;
    logic [23:0]         fault_reg, fault_next;
    logic [1:0]          dir_reg, dir_next;
    logic [2:0]          color_reg, color_next;
    logic [24:0]         x_reg, x_next;
    logic [14:0]         y_reg, y_next;
    logic [13:0]         head_reg, head_next;

    ptcd_pkg::data_t     b [ptcd_pkg::STORE_DEPTH];
    logic [23:0]         join24;
    logic [13:0]         y_raw;
    logic                tag_in_view, lane;

    // state only moves when the result word is free to take the new status
    assign pop = job_valid && (!valid_reg || m_ready);

    always_comb begin
        for (int i = 0; i < ptcd_pkg::STORE_DEPTH; i++) begin
            b[i] = job.bytes[i];
        end
    end

    assign join24      = {b[2][2:0], b[3], b[4], b[5]};
    assign y_raw       = {b[6], b[7]};
    assign tag_in_view = b[1][ptcd_pkg::TAG_BIT];
    assign lane        = !b[0][ptcd_pkg::NOLANE_BIT];

    always_comb begin
        status_next = job.status;
        lane_next   = lane_reg;
        tag_next    = tag_reg;
        tagnum_next = tagnum_reg;
        fault_next  = fault_reg;
        dir_next    = dir_reg;
        color_next  = color_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        head_next   = head_reg;
        if (job.status == ptcd_pkg::ST_OK) begin
            case (job.kind)
                ptcd_pkg::KIND_DIR: begin
                    dir_next = b[1][1:0];
                end
                ptcd_pkg::KIND_COLOR: begin
                    if (b[0][2:0] != 3'd0 && b[1][2:0] != 3'd0) begin
                        color_next = b[1][2:0];
                    end
                end
                ptcd_pkg::KIND_POS: begin
                    if (b[0][ptcd_pkg::FAULT_BIT]) begin
                        fault_next  = join24;
                        status_next = ptcd_pkg::ST_SENSOR;
                    end else begin
                        lane_next = lane;
                        tag_next  = tag_in_view;
                        if (tag_in_view) begin
                            tagnum_next = {b[14], b[15], b[16], b[17]};
                        end
                        if (tag_in_view || lane) begin
                            head_next = {b[10], b[11]};
                            // above 2^23 with a tag: x - 2^24, i.e. sign-extend
                            if (tag_in_view && join24[23] && (join24[22:0] != '0)) begin
                                x_next = {1'b1, join24};
                            end else begin
                                x_next = {1'b0, join24};
                            end
                            // above 2^13: y - 2^14
                            if (y_raw[13] && (y_raw[12:0] != '0)) begin
                                y_next = {1'b1, y_raw};
                            end else begin
                                y_next = {1'b0, y_raw};
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            status_reg <= ptcd_pkg::ST_OK;
            lane_reg   <= 1'b0;
            tag_reg    <= 1'b0;
            tagnum_reg <= '0;
            fault_reg  <= '0;
            dir_reg    <= '0;
            color_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            head_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                status_reg <= status_next;
                lane_reg   <= lane_next;
                tag_reg    <= tag_next;
                tagnum_reg <= tagnum_next;
                fault_reg  <= fault_next;
                dir_reg    <= dir_next;
                color_reg  <= color_next;
                x_reg      <= x_next;
                y_reg      <= y_next;
                head_reg   <= head_next;
            end
        end
    end

    assign m_valid       = valid_reg;
    assign status        = status_reg;
    assign lane_detected = lane_reg;
    assign tag_seen      = tag_reg;
    assign tag_number    = tagnum_reg;
    assign fault_code    = fault_reg;
    assign direction     = dir_reg;
    assign color         = color_reg;
    assign x_position    = x_reg;
    assign y_position    = y_reg;
    assign heading       = head_reg;

endmodule

// File: hdl/position_telegram_checker_decoder.sv
// position_telegram_checker_decoder: top level of the reply telegram decoder.
// Depends on ptcd_pkg, ptcd_front, ptcd_queue and ptcd_back.
//
//  channel | ports                                   | word
//  --------+-----------------------------------------+-------------------------------
//  input   | s_valid s_ready s_cmd s_rx_byte s_last  | one telegram byte + kind
//  result  | m_valid m_ready m_status m_* stored     | one per checksum byte
//
// One input word per cycle while s_ready is high; each accepted word is taken by the front end.
// A checksum word is written into the job queue and from there into the result register
// once the result register is free; the 2-entry job queue plus the
// result register hold up to 3 finished telegrams while m_ready is low.
// s_ready drops only when the job queue is full.
// aresetn (synchronous, active low) clears counters, queue and all stored result values.
module position_telegram_checker_decoder #(
    parameter int DIR_REPLY_LEN   = 3,
    parameter int COLOR_REPLY_LEN = 3,
    parameter int POS_REPLY_LEN   = 21
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [7:0]          s_rx_byte,
    input  logic                s_last,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic                m_lane_detected,
    output logic                m_tag_seen,
    output logic [27:0]         m_tag_number,
    output logic [23:0]         m_fault_code,
    output logic [1:0]          m_direction,
    output logic [2:0]          m_color,
    output logic signed [24:0]  m_x_position,
    output logic signed [14:0]  m_y_position,
    output logic [13:0]         m_heading
);

    logic                q_full;
    logic                q_not_empty;
    logic                push;
    logic                pop;
    logic                accept;
    ptcd_pkg::job_t      front_job;
    ptcd_pkg::job_t      head_job;
    ptcd_pkg::status_t   status;

    // every word waits on the queue, so a checksum word is never dropped
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    ptcd_front #(
        .DIR_REPLY_LEN   (DIR_REPLY_LEN),
        .COLOR_REPLY_LEN (COLOR_REPLY_LEN),
        .POS_REPLY_LEN   (POS_REPLY_LEN)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .cmd     (s_cmd),
        .rx_byte (s_rx_byte),
        .last    (s_last),
        .push    (push),
        .job     (front_job)
    );

    ptcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (front_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    ptcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_not_empty),
        .job           (head_job),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .status        (status),
        .lane_detected (m_lane_detected),
        .tag_seen      (m_tag_seen),
        .tag_number    (m_tag_number),
        .fault_code    (m_fault_code),
        .direction     (m_direction),
        .color         (m_color),
        .x_position    (m_x_position),
        .y_position    (m_y_position),
        .heading       (m_heading)
    );

    assign m_status = status;

endmodule

// File: hdl/ptcd_checker.sv
// ptcd_checker: port-level assertions for the telegram decoder, bound to the top.
// Depends on ptcd_pkg and position_telegram_checker_decoder.
module ptcd_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [2:0]   m_status,
    input  logic [1:0]   m_direction,
    input  logic [2:0]   m_color,
    input  logic [27:0]  m_tag_number,
    input  logic [13:0]  m_heading
);

    // result valid and status hold while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result word changed while stalled");

    // only defined status codes
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ptcd_pkg::ST_OK || m_status == ptcd_pkg::ST_LEN ||
                     m_status == ptcd_pkg::ST_CHK || m_status == ptcd_pkg::ST_SENSOR ||
                     m_status == ptcd_pkg::ST_KIND))
        else $error("undefined status code");

    // reset empties the result register
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stored values move only together with a new result word
    a_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(aresetn) |-> $stable(m_direction) && $stable(m_color) &&
                                       $stable(m_tag_number) && $stable(m_heading))
        else $error("stored value changed without a result");

endmodule

bind position_telegram_checker_decoder ptcd_checker u_ptcd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_direction  (m_direction),
    .m_color      (m_color),
    .m_tag_number (m_tag_number),
    .m_heading    (m_heading)
);
